/* rtl/cws_pkg.sv */
`timescale 1ns / 1ps

package cws_pkg;

  localparam int SEQ_W = 32;
  localparam int PAY_W = 12;
  localparam int WS_W  = 6;
  localparam int DUP_W = 3;

  // Event commands.
  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_PAYLOAD   = 1'b0;
  localparam logic CFG_FIXED_WIN = 1'b1;

  localparam logic [PAY_W-1:0] PAYLOAD_RESET = 12'd1024;
  localparam logic [DUP_W-1:0] DUP_MAX       = 3'd7;
  localparam logic [DUP_W-1:0] DUP_ACT       = 3'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [SEQ_W-1:0] total_bytes;
    logic [SEQ_W-1:0] ack_seq;
  } event_word_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] byte_offset;
    logic [PAY_W-1:0] seg_bytes;
    logic             is_resend;
    logic             done_res;
    logic             last;
  } seg_word_t;

  // One ring entry: where a segment starts in the transfer and how long it is.
  typedef struct packed {
    logic [SEQ_W-1:0] offset;
    logic [PAY_W-1:0] length;
  } seg_entry_t;

  typedef struct packed {
    logic [WS_W-1:0] size;
    logic            slow_start;
    logic [WS_W-1:0] frac;
  } win_t;

  // Window growth after an event: one segment per event in slow start, one per
  // window's worth of events in congestion avoidance, capped at max_ws.
  function automatic win_t grow_window(win_t w, logic [SEQ_W-1:0] thr,
                                       logic [WS_W-1:0] max_ws);
    win_t r;
    r = w;
    if (w.size < max_ws) begin
      if (w.slow_start) begin
        r.size = w.size + 1'b1;
        if (SEQ_W'(r.size) >= thr) begin
          r.slow_start = 1'b0;
          r.frac       = '0;
        end
      end else begin
        r.frac = w.frac + 1'b1;
        if (r.frac == w.size) begin
          r.size = w.size + 1'b1;
          r.frac = '0;
        end
      end
    end
    return r;
  endfunction

endpackage

/* rtl/cws_ring.sv */
`timescale 1ns / 1ps

module cws_ring #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  cws_pkg::seg_entry_t wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output cws_pkg::seg_entry_t rdata
);
  import cws_pkg::*;

  seg_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/cws_out_reg.sv */
`timescale 1ns / 1ps

module cws_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_valid,
  input  cws_pkg::seg_word_t load_word,
  output logic               load_ready,
  output logic               valid,
  output cws_pkg::seg_word_t word,
  input  logic               stall
);
  import cws_pkg::*;

  // A new word may enter when the register is empty or its word leaves now.
  assign load_ready = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= load_valid;
    end
    if (load_ready && load_valid) begin
      word <= load_word;
    end
  end

endmodule

/* rtl/cws_engine.sv */
`timescale 1ns / 1ps

module cws_engine #(
  parameter int MAX_SEG = 32,
  parameter int SW      = 5,
  parameter int OW      = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       ev_valid,
  input  cws_pkg::event_word_t       ev_word,
  output logic                       ev_stall,
  input  logic [cws_pkg::PAY_W-1:0]  pay,
  input  logic [cws_pkg::WS_W-1:0]   fw,
  output logic                       emit_valid,
  output cws_pkg::seg_word_t         emit_word,
  input  logic                       emit_ready,
  output logic                       mem_we,
  output logic [SW-1:0]              mem_waddr,
  output cws_pkg::seg_entry_t        mem_wdata,
  output logic                       mem_re,
  output logic [SW-1:0]              mem_raddr,
  input  cws_pkg::seg_entry_t        mem_rdata
);
  import cws_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EVT, S_UPD, S_RSND, S_SEND, S_DONE} state_t;

  state_t           state;
  logic [1:0]       cmd_r;
  logic [SEQ_W-1:0] ack_r;
  logic [SEQ_W-1:0] total_r;
  logic [SEQ_W-1:0] base;
  logic [SEQ_W-1:0] nseq;
  logic [SEQ_W-1:0] thr;
  logic [SEQ_W-1:0] ack_last;
  logic [SEQ_W-1:0] bq;
  logic [SEQ_W-1:0] rem;
  logic [OW-1:0]    out_cnt;
  logic [SW-1:0]    base_slot;
  logic [SW-1:0]    next_slot;
  win_t             win;
  logic [DUP_W-1:0] dup;
  logic             dup3_r;
  logic             ack_ge_r;
  logic             resend_r;
  logic [SEQ_W-1:0] ack_dist_r;
  logic [SEQ_W-1:0] rdist_r;
  logic [SEQ_W-1:0] rseq_r;

  logic             ack_same;
  logic [DUP_W-1:0] dup_inc;
  logic             rs_ok;
  logic             ack_in;
  logic [OW-1:0]    adv;
  logic [WS_W-1:0]  size_h;
  logic [SEQ_W-1:0] thr_n;
  win_t             w_pre;
  win_t             w_mid;
  win_t             w_fin;
  logic [SW-1:0]    r_slot;
  logic [SW-1:0]    slide_slot;
  logic [SW-1:0]    next_slot_inc;
  logic             send_more;
  logic             more_after;
  logic             done_now;
  logic [PAY_W-1:0] seg_len;
  logic             fire;

  // Ring slot of (s + d) where s is a slot and d is at most MAX_SEG.
  function automatic logic [SW-1:0] slot_add(logic [SW-1:0] s, logic [OW-1:0] d);
    logic [OW:0] t;
    t = (OW+1)'(s) + (OW+1)'(d);
    if (t >= (OW+1)'(MAX_SEG)) begin
      t = t - (OW+1)'(MAX_SEG);
    end
    return t[SW-1:0];
  endfunction

  always_comb begin
    ack_same = (ack_r == ack_last);
    dup_inc  = (dup < DUP_MAX) ? dup + 1'b1 : dup;

    // Outstanding counts never exceed the window cap, so distances compare
    // against the narrow count once their upper bits are known to be zero.
    rs_ok  = ((rdist_r >> OW) == '0) && (rdist_r[OW-1:0] < out_cnt);
    ack_in = ((ack_dist_r >> OW) == '0) && (ack_dist_r[OW-1:0] < out_cnt);
    adv    = ack_in ? ack_dist_r[OW-1:0] + 1'b1 : out_cnt;
    size_h = WS_W'(({1'b0, win.size} + 7'd1) >> 1);

    unique case (cmd_r)
      CMD_TIMEOUT: begin
        thr_n = SEQ_W'(win.size >> 1);
        w_pre = '{size: WS_W'(1), slow_start: 1'b1, frac: win.frac};
      end
      default: begin
        if (dup3_r) begin
          thr_n = SEQ_W'(size_h);
          w_pre = '{size: size_h, slow_start: 1'b0, frac: '0};
        end else begin
          thr_n = thr;
          w_pre = win;
        end
      end
    endcase
    w_mid = grow_window(w_pre, thr_n, WS_W'(MAX_SEG));
    w_fin = (cmd_r == CMD_START) ? win : w_mid;
    if (fw != '0) begin
      w_fin.size = fw;
    end

    r_slot        = slot_add(base_slot, rdist_r[OW-1:0]);
    slide_slot    = slot_add(base_slot, adv);
    next_slot_inc = (next_slot == SW'(MAX_SEG - 1)) ? '0 : next_slot + 1'b1;

    send_more  = (WS_W'(out_cnt) < win.size) && (rem != '0);
    more_after = ((WS_W'(out_cnt) + 1'b1) < win.size) && (rem > SEQ_W'(pay));
    done_now   = (rem == '0) && (out_cnt == '0);
    seg_len    = (rem >= SEQ_W'(pay)) ? pay : rem[PAY_W-1:0];

    emit_valid = 1'b0;
    emit_word  = '0;
    unique case (state)
      S_RSND: begin
        emit_valid            = resend_r;
        emit_word.seq         = rseq_r;
        emit_word.byte_offset = mem_rdata.offset;
        emit_word.seg_bytes   = mem_rdata.length;
        emit_word.is_resend   = 1'b1;
        emit_word.last        = !send_more && !done_now;
      end
      S_SEND: begin
        emit_valid            = send_more;
        emit_word.seq         = nseq;
        emit_word.byte_offset = bq;
        emit_word.seg_bytes   = seg_len;
        emit_word.last        = !more_after;
      end
      S_DONE: begin
        emit_valid         = 1'b1;
        emit_word.done_res = 1'b1;
        emit_word.last     = 1'b1;
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
    fire = emit_valid && emit_ready;
  end

  assign ev_stall  = (state != S_IDLE);
  assign mem_we    = (state == S_SEND) && fire;
  assign mem_waddr = next_slot;
  assign mem_wdata = '{offset: bq, length: seg_len};
  assign mem_re    = (state == S_UPD);
  assign mem_raddr = r_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      base      <= SEQ_W'(1);
      nseq      <= SEQ_W'(1);
      out_cnt   <= '0;
      base_slot <= SW'(1);
      next_slot <= SW'(1);
      win       <= '{size: WS_W'(1), slow_start: 1'b1, frac: '0};
      thr       <= '1;
      ack_last  <= '0;
      dup       <= '0;
      bq        <= '0;
      rem       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ev_valid) begin
            cmd_r   <= ev_word.cmd;
            ack_r   <= ev_word.ack_seq;
            total_r <= ev_word.total_bytes;
            if (ev_word.cmd != CMD_NONE) begin
              state <= S_EVT;
            end
          end
        end
        S_EVT: begin
          if (cmd_r == CMD_ACK) begin
            if (ack_same) begin
              dup <= dup_inc;
            end else begin
              ack_last <= ack_r;
              dup      <= '0;
            end
          end
          dup3_r     <= (cmd_r == CMD_ACK) && ack_same && (dup_inc == DUP_ACT);
          ack_dist_r <= ack_r - base;
          ack_ge_r   <= (ack_r >= base);
          rdist_r    <= (cmd_r == CMD_TIMEOUT) ? '0 : ack_r - base + 1'b1;
          state      <= S_UPD;
        end
        S_UPD: begin
          resend_r <= (cmd_r == CMD_TIMEOUT || dup3_r) && rs_ok;
          rseq_r   <= base + rdist_r;
          win      <= w_fin;
          unique case (cmd_r)
            CMD_START: begin
              rem <= total_r;
              bq  <= '0;
            end
            CMD_TIMEOUT: begin
              thr <= thr_n;
            end
            default: begin
              if (dup3_r) begin
                thr <= thr_n;
              end else if (ack_ge_r) begin
                base      <= base + SEQ_W'(adv);
                out_cnt   <= out_cnt - adv;
                base_slot <= slide_slot;
              end
            end
          endcase
          state <= S_RSND;
        end
        S_RSND: begin
          if (!resend_r || emit_ready) begin
            state <= S_SEND;
          end
        end
        S_SEND: begin
          if (send_more) begin
            if (fire) begin
              bq        <= bq + SEQ_W'(seg_len);
              rem       <= rem - SEQ_W'(seg_len);
              nseq      <= nseq + 1'b1;
              out_cnt   <= out_cnt + 1'b1;
              next_slot <= next_slot_inc;
            end
          end else if (done_now) begin
            state <= S_DONE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DONE: begin
          if (emit_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/congestion_window_sender.sv */
`timescale 1ns / 1ps

// Channel   Signals                              Direction  Word
// event     event_valid, event_stall, event_word  in        cmd, total_bytes, ack_seq
// segment   seg_valid, seg_stall, seg_word        out       seq, offset, length, flags
// config    cfg_write, cfg_index, cfg_data        in        payload size, fixed window
//
// An event word passes through its bookkeeping states in order (accept, ack compare,
// window update, resend slot, send exit check); a resend word leaves in the resend
// slot, new segments and the done word leave from the send and done states, at one
// result word per cycle while the segment output does not stall.
// Reset is synchronous and active high; it restores the window state, while the
// ring holds whatever it held. A stalled segment output holds the engine, and no
// new event word is taken until the current one has finished.

module congestion_window_sender #(
  parameter int MAX_WINDOW_SEGMENTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          event_valid,
  input  cws_pkg::event_word_t          event_word,
  output logic                          event_stall,
  output logic                          seg_valid,
  output cws_pkg::seg_word_t            seg_word,
  input  logic                          seg_stall,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [cws_pkg::PAY_W-1:0]     cfg_data
);
  import cws_pkg::*;

  // Ring slot index width, and the width of the outstanding-segment count,
  // which can reach the full window.
  localparam int SLOT_W = (MAX_WINDOW_SEGMENTS > 1) ? $clog2(MAX_WINDOW_SEGMENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW_SEGMENTS + 1);

  logic [PAY_W-1:0] payload_bytes;
  logic [WS_W-1:0]  fixed_window;
  logic [PAY_W-1:0] pay_eff;
  logic [WS_W-1:0]  fw_eff;

  logic             emit_valid;
  seg_word_t        emit_word;
  logic             emit_ready;
  logic             mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  seg_entry_t       mem_wdata;
  logic             mem_re;
  logic [SLOT_W-1:0] mem_raddr;
  seg_entry_t       mem_rdata;

  // Configuration registers. A zero payload size behaves as one byte, and a
  // fixed window larger than the ring is clipped to the ring size.
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bytes <= PAYLOAD_RESET;
      fixed_window  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PAYLOAD:   payload_bytes <= cfg_data;
        CFG_FIXED_WIN: fixed_window  <= cfg_data[WS_W-1:0];
        default:       payload_bytes <= payload_bytes;
      endcase
    end
  end

  assign pay_eff = (payload_bytes == '0) ? PAY_W'(1) : payload_bytes;
  assign fw_eff  = (fixed_window > WS_W'(MAX_WINDOW_SEGMENTS)) ?
                   WS_W'(MAX_WINDOW_SEGMENTS) : fixed_window;

  // Window and sequence bookkeeping; issues one result word per cycle while sending, unless held by a stalled output.
  cws_engine #(
    .MAX_SEG (MAX_WINDOW_SEGMENTS),
    .SW      (SLOT_W),
    .OW      (CNT_W)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .ev_valid   (event_valid),
    .ev_word    (event_word),
    .ev_stall   (event_stall),
    .pay        (pay_eff),
    .fw         (fw_eff),
    .emit_valid (emit_valid),
    .emit_word  (emit_word),
    .emit_ready (emit_ready),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // Ring of segment offsets and lengths, indexed by sequence number modulo
  // the ring size; read on every event update, but used only for retransmissions.
  cws_ring #(
    .DEPTH (MAX_WINDOW_SEGMENTS),
    .AW    (SLOT_W)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register between the engine and the segment channel.
  cws_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (emit_valid),
    .load_word  (emit_word),
    .load_ready (emit_ready),
    .valid      (seg_valid),
    .word       (seg_word),
    .stall      (seg_stall)
  );

`ifndef SYNTHESIS
  // A completion word carries no segment and always closes its event.
  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_word.done_res |->
      seg_word.last && !seg_word.is_resend && seg_word.seg_bytes == '0)
    else $error("done word with segment fields or without last");

  // Every segment, new or resent, carries at least one byte.
  a_seg_len: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_word.done_res |-> seg_word.seg_bytes != '0)
    else $error("segment word with zero length");

  // Once a real event is taken, the input is held off while it is processed.
  a_busy_after_event: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_stall && event_word.cmd != CMD_NONE |=> event_stall)
    else $error("event input not held off after accepting an event");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import cws_pkg::*;

  // The ring in the block holds one entry per window slot, indexed by the low
  // bits of the sequence number.
  localparam int RING_DEPTH = 32;
  localparam int SLOT_W = $clog2(RING_DEPTH);

  // An event word can keep the block busy for a full window of segment words
  // plus its bookkeeping states, and may end with no segment word at all.
  // This many quiet cycles cover that before the registers are touched.
  localparam int DRAIN_CYCLES = RING_DEPTH + 20;

  // Complete picture of the sender between events, plus its two registers.
  typedef struct packed {
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] next_seq;
    logic [SEQ_W-1:0] thresh;
    logic [SEQ_W-1:0] last_ack;
    logic [SEQ_W-1:0] queued;
    logic [SEQ_W-1:0] length;
    logic [WS_W-1:0] wsize;
    logic [WS_W-1:0] frac;
    logic slow;
    logic [DUP_W-1:0] dups;
    logic [PAY_W-1:0] payload;
    logic [WS_W-1:0] fixed_win;
    seg_entry_t [RING_DEPTH-1:0] ring;
  } window_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic event_valid = 1'b0;
  event_word_t event_word = '0;
  logic event_stall;
  logic seg_valid;
  seg_word_t seg_word;
  logic seg_stall = 1'b0;
  logic cfg_write = 1'b0;
  logic cfg_index = CFG_PAYLOAD;
  logic [PAY_W-1:0] cfg_data = '0;

  // The model follows the words the block has actually taken. The plan runs
  // ahead of it: it is stepped as words are queued, so that well-formed acks
  // can be aimed at the window the block will have by then.
  window_state_t model;
  window_state_t plan;

  event_word_t event_backlog[$];
  seg_word_t segments_due[$];
  seg_word_t due_word;

  int events_queued = 0;
  int events_launched = 0;
  int events_taken = 0;
  int mismatches = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  congestion_window_sender #(
    .MAX_WINDOW_SEGMENTS(RING_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .event_valid(event_valid),
    .event_word(event_word),
    .event_stall(event_stall),
    .seg_valid(seg_valid),
    .seg_word(seg_word),
    .seg_stall(seg_stall),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic window_state_t state_after_reset();
    window_state_t st;
    st = '0;
    st.base = 1;
    st.next_seq = 1;
    st.wsize = WS_W'(1);
    st.thresh = '1;
    st.slow = 1'b1;
    st.payload = PAYLOAD_RESET;
    return st;
  endfunction

  // Slow start adds a segment per event and leaves once the threshold is
  // reached; congestion avoidance adds one per window's worth of events.
  function automatic void widen_window(inout window_state_t st);
    if (32'(st.wsize) < RING_DEPTH) begin
      if (st.slow) begin
        st.wsize = st.wsize + 1'b1;
        if (32'(st.wsize) >= st.thresh) begin
          st.slow = 1'b0;
          st.frac = '0;
        end
      end else begin
        st.frac = st.frac + 1'b1;
        if (st.frac == st.wsize) begin
          st.wsize = st.wsize + 1'b1;
          st.frac = '0;
        end
      end
    end
  endfunction

  // A resend goes out only if the segment is still outstanding, that is, its
  // sequence number lies in [base, next_seq).
  function automatic bit ring_resend(input window_state_t st, input logic [SEQ_W-1:0] s,
                                     output seg_word_t w);
    logic [SEQ_W-1:0] gap;
    logic [SEQ_W-1:0] span;
    gap = s - st.base;
    span = st.next_seq - st.base;
    w = '0;
    w.seq = s;
    w.byte_offset = st.ring[s[SLOT_W-1:0]].offset;
    w.seg_bytes = st.ring[s[SLOT_W-1:0]].length;
    w.is_resend = 1'b1;
    return gap < span;
  endfunction

  // Steps the sender by one event word. With keep set, the segment words it
  // causes are appended to the list of words the block owes us.
  function automatic void run_event(inout window_state_t st, input event_word_t ev,
                                    input bit keep);
    seg_word_t burst[$];
    seg_word_t w;
    logic [SEQ_W-1:0] span;
    logic [SEQ_W-1:0] pay;
    logic [SEQ_W-1:0] len;
    logic [63:0] adv;
    burst = {};
    if (ev.cmd == CMD_NONE) return;
    case (ev.cmd)
      CMD_START: begin
        st.length = ev.total_bytes;
        st.queued = '0;
      end
      CMD_TIMEOUT: begin
        st.thresh = 32'(st.wsize >> 1);
        st.wsize = WS_W'(1);
        st.slow = 1'b1;
        if (ring_resend(st, st.base, w)) burst.push_back(w);
        widen_window(st);
      end
      default: begin
        if (ev.ack_seq == st.last_ack) begin
          if (st.dups < DUP_MAX) st.dups = st.dups + 1'b1;
        end else begin
          st.last_ack = ev.ack_seq;
          st.dups = '0;
        end
        if (st.dups == DUP_ACT) begin
          // Fast retransmit: resend the segment after the repeated ack and
          // halve the window.
          if (ring_resend(st, ev.ack_seq + 1, w)) burst.push_back(w);
          st.wsize = 6'(({1'b0, st.wsize} + 7'd1) >> 1);
          st.thresh = 32'(st.wsize);
          st.slow = 1'b0;
          st.frac = '0;
        end else if (ev.ack_seq >= st.base) begin
          adv = 64'(ev.ack_seq - st.base) + 64'd1;
          span = st.next_seq - st.base;
          if (adv > 64'(span)) adv = 64'(span);
          st.base = st.base + adv[SEQ_W-1:0];
        end
        widen_window(st);
      end
    endcase

    pay = (st.payload == '0) ? 32'd1 : 32'(st.payload);
    if (st.fixed_win != '0) begin
      st.wsize = (32'(st.fixed_win) > RING_DEPTH) ? 6'(RING_DEPTH) : st.fixed_win;
    end
    while ((st.next_seq - st.base) < 32'(st.wsize) && st.queued < st.length) begin
      if (64'(st.queued) + 64'(pay) <= 64'(st.length)) len = pay;
      else len = st.length - st.queued;
      st.ring[st.next_seq[SLOT_W-1:0]].offset = st.queued;
      st.ring[st.next_seq[SLOT_W-1:0]].length = len[PAY_W-1:0];
      w = '0;
      w.seq = st.next_seq;
      w.byte_offset = st.queued;
      w.seg_bytes = len[PAY_W-1:0];
      burst.push_back(w);
      st.queued = st.queued + len;
      st.next_seq = st.next_seq + 1;
    end

    if (st.queued == st.length && st.next_seq == st.base) begin
      w = '0;
      w.done_res = 1'b1;
      burst.push_back(w);
    end

    if (keep && burst.size() > 0) begin
      burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) segments_due.push_back(burst[i]);
    end
  endfunction

  function automatic void check_field(string field, logic [SEQ_W-1:0] want,
                                      logic [SEQ_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Transfer lengths mostly span up to 24 segments of payload; now and then a
  // length with random upper bits goes in, which no ack sequence here will
  // ever finish.
  function automatic logic [SEQ_W-1:0] pick_length();
    logic [SEQ_W-1:0] pay;
    pay = (plan.payload == '0) ? 32'd1 : 32'(plan.payload);
    if ($urandom_range(99) < 5) return $urandom;
    return $urandom_range(pay * 24);
  endfunction

  task automatic queue_event(input logic [1:0] cmd, input logic [SEQ_W-1:0] total,
                             input logic [SEQ_W-1:0] ack);
    event_word_t ev;
    ev.cmd = cmd;
    ev.total_bytes = total;
    ev.ack_seq = ack;
    run_event(plan, ev, 1'b0);
    event_backlog.push_back(ev);
    events_queued++;
  endtask

  // Waits until every queued word has been taken and every owed segment word
  // has come back, then lets the engine run dry.
  task automatic settle();
    while (events_taken != events_queued || segments_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [PAY_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_PAYLOAD) model.payload = data;
    else model.fixed_win = data[WS_W-1:0];
    plan = model;
  endtask

  // Random traffic. Most of it follows the protocol: a start once the previous
  // transfer is done, acks that land inside the outstanding window, bursts of
  // repeated acks for fast retransmit, and timeouts. The rest is abandoned
  // transfers, ignored commands and words with fully random fields.
  task automatic queue_random(input int count);
    int made;
    int roll;
    int reps;
    logic [SEQ_W-1:0] a;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(99);
      if (plan.queued == plan.length && plan.next_seq == plan.base && roll < 70) begin
        queue_event(CMD_START, pick_length(), $urandom);
        made++;
      end else if (roll < 55) begin
        a = plan.base - 1 + $urandom_range(plan.next_seq - plan.base);
        queue_event(CMD_ACK, $urandom, a);
        made++;
      end else if (roll < 68) begin
        a = plan.base - 1;
        reps = $urandom_range(6, 4);
        repeat (reps) queue_event(CMD_ACK, $urandom, a);
        made += reps;
      end else if (roll < 78) begin
        queue_event(CMD_TIMEOUT, $urandom, $urandom);
        made++;
      end else if (roll < 84) begin
        queue_event(CMD_START, pick_length(), $urandom);
        made++;
      end else if (roll < 88) begin
        queue_event(CMD_NONE, $urandom, $urandom);
      end else begin
        queue_event(2'($urandom_range(2)), $urandom, $urandom);
        made++;
      end
    end
  endtask

  // Sender side: a new word goes out only once the current one has been
  // taken, and then only if the idle draw allows it. Words change at the
  // falling edge so they are stable at the rising edge that samples them.
  always @(negedge clk) begin
    seg_stall <= ($urandom_range(99) < stall_pct);
    if (rst) begin
      event_valid <= 1'b0;
    end else if (events_taken == events_launched) begin
      if (event_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
        event_word <= event_backlog.pop_front();
        event_valid <= 1'b1;
        events_launched++;
      end else begin
        event_valid <= 1'b0;
      end
    end
  end

  // Receiver side: every word taken on the event channel steps the model, and
  // every segment word taken is checked against the oldest one owed.
  always @(posedge clk) begin
    if (!rst) begin
      if (event_valid && !event_stall) begin
        run_event(model, event_word, 1'b1);
        events_taken++;
      end
      if (seg_valid && !seg_stall) begin
        if (segments_due.size() == 0) begin
          $error("segment word with none expected: seq %0h done %0b", seg_word.seq,
                 seg_word.done_res);
          mismatches++;
        end else begin
          due_word = segments_due.pop_front();
          check_field("seq", due_word.seq, seg_word.seq);
          check_field("byte_offset", due_word.byte_offset, seg_word.byte_offset);
          check_field("seg_bytes", 32'(due_word.seg_bytes), 32'(seg_word.seg_bytes));
          check_field("is_resend", 32'(due_word.is_resend), 32'(seg_word.is_resend));
          check_field("done_res", 32'(due_word.done_res), 32'(seg_word.done_res));
          check_field("last", 32'(due_word.last), 32'(seg_word.last));
        end
      end
    end
  end

  initial begin
    int p;
    model = state_after_reset();
    plan = model;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Directed part, registers at their reset values. Before any start the
    // transfer is empty, so every event but the ignored command reports completion.
    queue_event(CMD_ACK, '1, '0);
    queue_event(CMD_TIMEOUT, '0, '1);
    queue_event(CMD_NONE, '1, '1);
    queue_event(CMD_START, '0, '0);
    queue_event(CMD_START, 32'd5000, '0);
    queue_event(CMD_ACK, '0, 32'd1);
    // An ack far beyond the window slides only up to the next sequence.
    queue_event(CMD_ACK, '0, '1);
    // A stale ack, then the same value three more times: the third repeat
    // asks for a resend of a segment that is no longer outstanding.
    queue_event(CMD_ACK, '0, '0);
    repeat (3) queue_event(CMD_ACK, '0, '0);
    // More repeats run the duplicate counter into saturation.
    repeat (5) queue_event(CMD_ACK, '0, '0);
    queue_event(CMD_TIMEOUT, '0, '0);
    // Restart in the middle of a transfer with the largest length.
    queue_event(CMD_START, '1, '0);
    // Fast retransmit of a segment that is still outstanding.
    repeat (4) queue_event(CMD_ACK, '0, plan.base - 1);
    queue_event(CMD_START, 32'd3000, '0);
    queue_event(CMD_ACK, '0, plan.next_seq - 1);

    // Random phases, each with its own register setting and one of four idling patterns.
    for (p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(CFG_PAYLOAD, PAYLOAD_RESET);
          write_reg(CFG_FIXED_WIN, '0);
        end
        1: begin
          write_reg(CFG_PAYLOAD, 12'd1);
          write_reg(CFG_FIXED_WIN, 12'd63);
        end
        2: begin
          write_reg(CFG_PAYLOAD, 12'd4095);
          write_reg(CFG_FIXED_WIN, 12'd1);
        end
        3: begin
          write_reg(CFG_PAYLOAD, '0);
          write_reg(CFG_FIXED_WIN, 12'(RING_DEPTH));
        end
        default: begin
          write_reg(CFG_PAYLOAD, 12'($urandom_range(4094, 2)));
          write_reg(CFG_FIXED_WIN, 12'($urandom_range(31)));
        end
      endcase
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 69;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 69;
        end
        default: begin
          idle_pct = 26;
          stall_pct = 26;
        end
      endcase
      queue_random(80);
    end

    settle();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, with every word owed a full
  // window of segments behind long receiver stalls.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
